// ===== hw/rtl/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// Masked byte pattern search package
// Shared constants and types for the pattern cells and the top level.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // Operation codes carried by an input item.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_OFFSET   = 1'b1;

    // Fixed field widths.
    localparam int CFG_DATA_W    = 32;
    localparam int PLEN_W        = 7;
    localparam int ENTRY_INDEX_W = 6;
    localparam int BYTE_W        = 8;
    localparam int MATCH_OFFSET_W = 32;

    // Controls broadcast along the cell row.
    typedef struct packed {
        logic scan_en;
        logic restart;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/mbps_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one load or scan item.
// ----------------------------------------------------------------------------
interface mbps_in_if;

    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [mbps_pkg::ENTRY_INDEX_W-1:0] entry_index;
    logic [mbps_pkg::BYTE_W-1:0]        pattern_byte;
    logic                               must_match;
    logic [mbps_pkg::BYTE_W-1:0]        data_byte;
    logic                               is_last;

    modport source (
        output valid, operation, entry_index, pattern_byte, must_match, data_byte, is_last,
        input  ready
    );

    modport sink (
        input  valid, operation, entry_index, pattern_byte, must_match, data_byte, is_last,
        output ready
    );

endinterface

// ===== hw/rtl/mbps_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one search result item.
// ----------------------------------------------------------------------------
interface mbps_out_if;

    logic                                valid;
    logic                                ready;
    logic                                found;
    logic [mbps_pkg::MATCH_OFFSET_W-1:0] match_offset;

    modport source (
        output valid, found, match_offset,
        input  ready
    );

    modport sink (
        input  valid, found, match_offset,
        output ready
    );

endinterface

// ===== hw/rtl/mbps_cell.sv =====
// ----------------------------------------------------------------------------
// Pattern cell
// Holds one pattern entry and the partial-match bit of its alignment.
// ----------------------------------------------------------------------------
module mbps_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mbps_pkg::cell_ctrl_t        ctrl,
    input  logic                        load_en,
    input  logic [mbps_pkg::BYTE_W-1:0] pattern_byte,
    input  logic                        must_match,
    input  logic [mbps_pkg::BYTE_W-1:0] data_byte,
    input  logic                        prev_match,
    output logic                        match_next,
    output logic                        partial
);

    logic [mbps_pkg::BYTE_W-1:0] expected_reg;
    logic                        care_reg;
    logic                        partial_reg;
    logic                        partial_next;
    logic                        hit;

    assign hit        = !care_reg || (expected_reg == data_byte);
    assign match_next = prev_match && hit;
    assign partial    = partial_reg;

    always_comb
    begin
        partial_next = partial_reg;
        if (ctrl.scan_en)
        begin
            partial_next = ctrl.restart ? 1'b0 : match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            expected_reg <= pattern_byte;
            care_reg     <= must_match;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 1'b0;
        end
        else
        begin
            partial_reg <= partial_next;
        end
    end

endmodule

// ===== hw/rtl/masked_byte_pattern_search_top.sv =====
// ----------------------------------------------------------------------------
// Masked byte pattern search
// Finds the first place in a byte section where a wildcard pattern matches.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake      Carries
//  in_ch     in   valid/ready    operation, entry_index, pattern_byte,
//                                must_match, data_byte, is_last
//  out_ch    out  valid/ready    found, match_offset
//  cfg_*     in   write enable   pattern_length (0), start_offset (1)
//
// The cell row updates all partial matches at once, so one item is
// accepted per cycle while the result register is empty or drains.
// A result appears in the output register the cycle after its item.
// Input ready drops only while a result waits and the sink holds off.
// Reset clears the partial matches and scan state; pattern entries must be
// loaded before they are used.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_top #(
    parameter int MAX_PATTERN  = 64,
    parameter int OFFSET_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    mbps_in_if.sink                             in_ch,
    mbps_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W  = (IDX_W + 1 > mbps_pkg::PLEN_W) ? IDX_W + 1 : mbps_pkg::PLEN_W;
    localparam int LOAD_W = (IDX_W > mbps_pkg::ENTRY_INDEX_W) ? IDX_W : mbps_pkg::ENTRY_INDEX_W;

    logic [IDX_W-1:0]                     tail_idx_reg;
    logic [IDX_W-1:0]                     tail_idx_next;
    logic [mbps_pkg::CFG_DATA_W-1:0]      start_offset_reg;
    logic [mbps_pkg::CFG_DATA_W-1:0]      start_offset_next;
    logic [OFFSET_WIDTH-1:0]              base_reg;
    logic [OFFSET_WIDTH-1:0]              base_next;
    logic [OFFSET_WIDTH-1:0]              scan_pos_reg;
    logic [OFFSET_WIDTH-1:0]              scan_pos_next;
    logic                                 reported_reg;
    logic                                 reported_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic                                 found_reg;
    logic                                 found_next;
    logic [mbps_pkg::MATCH_OFFSET_W-1:0]  offset_reg;
    logic [mbps_pkg::MATCH_OFFSET_W-1:0]  offset_next;

    logic [LEN_W-1:0]                     wr_len;
    logic [IDX_W-1:0]                     wr_tail;
    logic                                 in_fire;
    logic                                 scan_fire;
    logic                                 load_fire;
    logic                                 hit_now;
    logic                                 emit_found;
    logic                                 emit_miss;
    mbps_pkg::cell_ctrl_t                 ctrl;
    logic [MAX_PATTERN-1:0]               match_vec;
    logic [MAX_PATTERN-1:0]               partial_vec;
    logic [MAX_PATTERN-1:0]               prev_vec;
    logic [MAX_PATTERN-1:0]               load_vec;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign scan_fire   = in_fire && (in_ch.operation == mbps_pkg::OP_SCAN);
    assign load_fire   = in_fire && (in_ch.operation == mbps_pkg::OP_LOAD);

    assign ctrl.scan_en = scan_fire;
    assign ctrl.restart = in_ch.is_last;

    // Cell row: each cell takes the previous cell's partial match; cell zero
    // always sees an open alignment.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign prev_vec[gi] = 1'b1;
            end
            else
            begin : g_body
                assign prev_vec[gi] = partial_vec[gi-1];
            end

            assign load_vec[gi] = load_fire &&
                (LOAD_W'(in_ch.entry_index) == LOAD_W'(gi));

            mbps_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .load_en      (load_vec[gi]),
                .pattern_byte (in_ch.pattern_byte),
                .must_match   (in_ch.must_match),
                .data_byte    (in_ch.data_byte),
                .prev_match   (prev_vec[gi]),
                .match_next   (match_vec[gi]),
                .partial      (partial_vec[gi])
            );
        end
    endgenerate

    assign hit_now    = match_vec[tail_idx_reg];
    assign emit_found = scan_fire && !reported_reg && hit_now;
    assign emit_miss  = scan_fire && !reported_reg && !hit_now && in_ch.is_last;

    // Pattern length is clamped to 1..MAX_PATTERN and kept as its last index.
    always_comb
    begin
        wr_len = LEN_W'(cfg_wdata[mbps_pkg::PLEN_W-1:0]);
        if (wr_len == '0)
        begin
            wr_tail = '0;
        end
        else if (wr_len > LEN_W'(MAX_PATTERN))
        begin
            wr_tail = IDX_W'(MAX_PATTERN - 1);
        end
        else
        begin
            wr_tail = IDX_W'(wr_len - LEN_W'(1));
        end
    end

    // The base offset folds start_offset and the pattern length together so
    // a match needs only one add with the scan position.
    always_comb
    begin
        tail_idx_next     = tail_idx_reg;
        start_offset_next = start_offset_reg;
        base_next         = base_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mbps_pkg::CFG_PATTERN_LENGTH:
                begin
                    tail_idx_next = wr_tail;
                    base_next     = OFFSET_WIDTH'(start_offset_reg) - OFFSET_WIDTH'(wr_tail);
                end
                mbps_pkg::CFG_START_OFFSET:
                begin
                    start_offset_next = cfg_wdata;
                    base_next         = OFFSET_WIDTH'(cfg_wdata) - OFFSET_WIDTH'(tail_idx_reg);
                end
                default:
                begin
                    tail_idx_next = tail_idx_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        scan_pos_next = scan_pos_reg;
        reported_next = reported_reg;
        if (scan_fire)
        begin
            if (in_ch.is_last)
            begin
                scan_pos_next = '0;
                reported_next = 1'b0;
            end
            else
            begin
                scan_pos_next = scan_pos_reg + OFFSET_WIDTH'(1);
                reported_next = reported_reg || hit_now;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        offset_next    = offset_reg;
        if (emit_found || emit_miss)
        begin
            out_valid_next = 1'b1;
            found_next     = emit_found;
            offset_next    = emit_found ?
                mbps_pkg::MATCH_OFFSET_W'(base_reg + scan_pos_reg) : '0;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_idx_reg     <= '0;
            start_offset_reg <= '0;
            base_reg         <= '0;
            scan_pos_reg     <= '0;
            reported_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            tail_idx_reg     <= tail_idx_next;
            start_offset_reg <= start_offset_next;
            base_reg         <= base_next;
            scan_pos_reg     <= scan_pos_next;
            reported_reg     <= reported_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        offset_reg <= offset_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.found        = found_reg;
    assign out_ch.match_offset = offset_reg;

endmodule
